// ----- sv/slmb_pkg.sv -----
// Shared constants, register codes and stage control type for the level meter ballistics block.
`timescale 1ns / 1ps

package slmb_pkg;

  // Default geometry
  localparam int SLOTS_DEF      = 8;
  localparam int LEVEL_BITS_DEF = 16;

  // Fixed field widths
  localparam int SLOT_IDX_W = 3;
  localparam int RAW_W      = 16;
  localparam int OUT_W      = 16;
  localparam int COEF_W     = 16;
  localparam int HOLD_W     = 8;

  // Stream packing
  localparam int IN_TDATA_W  = 2 * RAW_W;
  localparam int IN_TUSER_W  = SLOT_IDX_W;
  localparam int OUT_TDATA_W = 4 * OUT_W;
  localparam int OUT_TUSER_W = SLOT_IDX_W + 1;

  // Config port
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [COEF_W-1:0] ATTACK_RST  = COEF_W'(32768);
  localparam logic [COEF_W-1:0] RELEASE_RST = COEF_W'(6554);
  localparam logic [COEF_W-1:0] DECAY_RST   = COEF_W'(62259);
  localparam logic [HOLD_W-1:0] HOLD_RST    = HOLD_W'(20);

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_ATTACK  = 2'd0,
    CFG_RELEASE = 2'd1,
    CFG_DECAY   = 2'd2,
    CFG_HOLD    = 2'd3
  } cfg_reg_e;

  // Control that travels with an item down the pipe
  typedef struct packed {
    logic                  valid;
    logic                  in_range;
    logic [SLOT_IDX_W-1:0] slot;
  } stage_ctl_t;

endpackage

// ----- sv/stereo_level_meter_ballistics.sv -----
// Top level: slot state memory, config registers, pipeline control, two lanes and merge.
`timescale 1ns / 1ps
// Path: an accepted tick moves through s1 (state read), s2 (lane registers) and the output register.
// Throughput: one tick per cycle while consecutive ticks hit different slots and the output
//   is not stalled; a tick for a slot still in flight waits until that slot's write-back
//   (read-modify-write through the registered state memory).
// Reset: config registers return to defaults; per-slot valid bits clear at once, so every
//   slot reads as zero until its first update. No clearing pass, ready right after reset.

module stereo_level_meter_ballistics #(
  parameter int SLOTS      = slmb_pkg::SLOTS_DEF,
  parameter int LEVEL_BITS = slmb_pkg::LEVEL_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input tick
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [slmb_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // raw_left, raw_right
  input  logic [slmb_pkg::IN_TUSER_W-1:0]   s_axis_tuser,  // slot_index
  // result
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [slmb_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,  // smooth_left, smooth_right,
                                                           // peak_left, peak_right
  output logic [slmb_pkg::OUT_TUSER_W-1:0]  m_axis_tuser,  // out_slot, signal_present
  // config write
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [slmb_pkg::CFG_ADDR_W-1:0]   cfg_addr_i,
  input  logic [slmb_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import slmb_pkg::*;

  localparam int LB     = LEVEL_BITS;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CMP_W  = 8;

  // one memory word per slot, both channels side by side
  typedef struct packed {
    logic [LB-1:0]     lvl_l;
    logic [LB-1:0]     peak_l;
    logic [HOLD_W-1:0] hold_l;
    logic [LB-1:0]     lvl_r;
    logic [LB-1:0]     peak_r;
    logic [HOLD_W-1:0] hold_r;
  } entry_t;

  // ---------------- config registers ----------------
  logic [COEF_W-1:0] attack_q;
  logic [COEF_W-1:0] release_q;
  logic [COEF_W-1:0] decay_q;
  logic [HOLD_W-1:0] hold_ticks_q;
  cfg_reg_e          cfg_sel;

  assign cfg_ready_o = 1'b1;
  assign cfg_sel     = cfg_reg_e'(cfg_addr_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attack_q     <= ATTACK_RST;
      release_q    <= RELEASE_RST;
      decay_q      <= DECAY_RST;
      hold_ticks_q <= HOLD_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_sel)
        CFG_ATTACK:  attack_q     <= cfg_data_i[COEF_W-1:0];
        CFG_RELEASE: release_q    <= cfg_data_i[COEF_W-1:0];
        CFG_DECAY:   decay_q      <= cfg_data_i[COEF_W-1:0];
        CFG_HOLD:    hold_ticks_q <= cfg_data_i[HOLD_W-1:0];
        default:     ;
      endcase
    end
  end

  // ---------------- pipeline control ----------------
  // s1: memory read data present, lanes compute products
  // s2: lanes apply step and peak update; write-back as the beat moves to the output reg
  stage_ctl_t          s1_q;
  stage_ctl_t          s2_q;
  logic [RAW_W-1:0]    raw_l_q;
  logic [RAW_W-1:0]    raw_r_q;
  logic                out_load;
  logic                adv1;
  logic                adv2;
  logic                slot_hit;
  logic                accept;
  logic [SLOT_IDX_W-1:0] in_slot;
  logic                in_range;
  logic [SLOT_W-1:0]   rd_idx;
  logic [SLOT_W-1:0]   wr_idx;
  logic                wr_en;

  assign in_slot  = s_axis_tuser[SLOT_IDX_W-1:0];
  assign in_range = CMP_W'(in_slot) < CMP_W'(SLOTS);
  assign rd_idx   = SLOT_W'(in_slot);
  assign wr_idx   = SLOT_W'(s2_q.slot);

  assign adv2 = !s2_q.valid || out_load;
  assign adv1 = !s1_q.valid || adv2;

  // hold off a tick whose slot has a read-modify-write still in flight
  assign slot_hit = (s1_q.valid && (s1_q.slot == in_slot)) ||
                    (s2_q.valid && (s2_q.slot == in_slot));

  assign s_axis_tready = adv1 && !slot_hit;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
      s2_q <= '0;
    end else begin
      if (adv1) begin
        s1_q.valid    <= accept;
        s1_q.in_range <= in_range;
        s1_q.slot     <= in_slot;
      end
      if (adv2) begin
        s2_q <= s1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      raw_l_q <= s_axis_tdata[RAW_W-1:0];
      raw_r_q <= s_axis_tdata[2*RAW_W-1:RAW_W];
    end
  end

  // ---------------- slot state memory ----------------
  entry_t            mem_q [SLOTS];
  entry_t            rd_q;
  logic              rd_vld_q;
  logic [SLOTS-1:0]  vld_q;
  entry_t            wr_data;

  assign wr_en = s2_q.valid && s2_q.in_range && out_load;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_idx] <= wr_data;
    end
    if (accept) begin
      rd_q     <= mem_q[rd_idx];
      rd_vld_q <= in_range && vld_q[rd_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_en) begin
      vld_q[wr_idx] <= 1'b1;
    end
  end

  // ---------------- lanes ----------------
  logic [LB-1:0]     lvl_l;
  logic [LB-1:0]     lvl_r;
  logic [LB-1:0]     peak_l;
  logic [LB-1:0]     peak_r;
  logic [HOLD_W-1:0] hold_l;
  logic [HOLD_W-1:0] hold_r;

  slmb_lane #(.LEVEL_BITS(LB)) u_lane_l (
    .clk_i        (clk_i),
    .adv_i        (adv2),
    .raw_i        (raw_l_q),
    .state_vld_i  (rd_vld_q),
    .lvl_i        (rd_q.lvl_l),
    .peak_i       (rd_q.peak_l),
    .hold_i       (rd_q.hold_l),
    .attack_i     (attack_q),
    .release_i    (release_q),
    .decay_i      (decay_q),
    .hold_ticks_i (hold_ticks_q),
    .lvl_o        (lvl_l),
    .peak_o       (peak_l),
    .hold_o       (hold_l)
  );

  slmb_lane #(.LEVEL_BITS(LB)) u_lane_r (
    .clk_i        (clk_i),
    .adv_i        (adv2),
    .raw_i        (raw_r_q),
    .state_vld_i  (rd_vld_q),
    .lvl_i        (rd_q.lvl_r),
    .peak_i       (rd_q.peak_r),
    .hold_i       (rd_q.hold_r),
    .attack_i     (attack_q),
    .release_i    (release_q),
    .decay_i      (decay_q),
    .hold_ticks_i (hold_ticks_q),
    .lvl_o        (lvl_r),
    .peak_o       (peak_r),
    .hold_o       (hold_r)
  );

  always_comb begin
    wr_data.lvl_l  = lvl_l;
    wr_data.peak_l = peak_l;
    wr_data.hold_l = hold_l;
    wr_data.lvl_r  = lvl_r;
    wr_data.peak_r = peak_r;
    wr_data.hold_r = hold_r;
  end

  // ---------------- merge / output register ----------------
  slmb_merge #(.LEVEL_BITS(LB)) u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (s2_q),
    .lvl_l_i       (lvl_l),
    .lvl_r_i       (lvl_r),
    .peak_l_i      (peak_l),
    .peak_r_i      (peak_r),
    .load_o        (out_load),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // ---------------- assertions ----------------
  // two in-flight beats never target the same slot
  a_no_slot_overlap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_q.valid && s2_q.valid) |-> (s1_q.slot != s2_q.slot))
    else $error("two in-flight beats share a slot");

  // a written slot reads as valid afterwards
  a_write_sets_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> vld_q[$past(wr_idx)])
    else $error("slot valid bit not set after write-back");

  // out-of-range slot yields an all-zero beat
  a_oor_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (CMP_W'(m_axis_tuser[SLOT_IDX_W-1:0]) >= CMP_W'(SLOTS)))
      |-> ((m_axis_tdata == '0) && !m_axis_tuser[SLOT_IDX_W]))
    else $error("out-of-range slot produced nonzero result");

  // present flag agrees with the smoothed levels when the output fields hold the full level
  a_present_flag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (LB <= OUT_W)) |->
      (m_axis_tuser[SLOT_IDX_W] == (m_axis_tdata[2*OUT_W-1:0] != '0)))
    else $error("signal_present disagrees with smoothed levels");

endmodule

// ----- sv/slmb_lane.sv -----
// One channel lane: one-pole smoother and peak hold/decay, one register stage between products and update.
`timescale 1ns / 1ps

module slmb_lane #(
  parameter int LEVEL_BITS = slmb_pkg::LEVEL_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          adv_i,
  input  logic [slmb_pkg::RAW_W-1:0]    raw_i,
  input  logic                          state_vld_i,
  input  logic [LEVEL_BITS-1:0]         lvl_i,
  input  logic [LEVEL_BITS-1:0]         peak_i,
  input  logic [slmb_pkg::HOLD_W-1:0]   hold_i,
  input  logic [slmb_pkg::COEF_W-1:0]   attack_i,
  input  logic [slmb_pkg::COEF_W-1:0]   release_i,
  input  logic [slmb_pkg::COEF_W-1:0]   decay_i,
  input  logic [slmb_pkg::HOLD_W-1:0]   hold_ticks_i,
  output logic [LEVEL_BITS-1:0]         lvl_o,
  output logic [LEVEL_BITS-1:0]         peak_o,
  output logic [slmb_pkg::HOLD_W-1:0]   hold_o
);
  import slmb_pkg::*;

  localparam int LB      = LEVEL_BITS;
  localparam int RW      = (RAW_W > LB) ? RAW_W : LB;
  localparam int PROD_W  = LB + COEF_W + 2;
  localparam int DPROD_W = LB + COEF_W;

  // stage 1: target, coefficient select, products
  logic [RW-1:0]             raw_ext;
  logic [RW-1:0]             max_ext;
  logic [LB-1:0]             target;
  logic [LB-1:0]             cur;
  logic [LB-1:0]             pk;
  logic [HOLD_W-1:0]         hd;
  logic [COEF_W-1:0]         coeff;
  logic signed [LB:0]        diff;
  logic signed [PROD_W-1:0]  prod;
  logic [DPROD_W-1:0]        dprod;

  logic [LB-1:0]             cur_q;
  logic [LB-1:0]             peak_q;
  logic [HOLD_W-1:0]         hold_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic [DPROD_W-1:0]        dprod_q;

  // stage 2: apply step, saturate, peak update
  logic signed [PROD_W-1:0]  step_full;
  logic signed [LB+1:0]      step;
  logic signed [LB+1:0]      sum;
  logic [LB-1:0]             new_lvl;

  assign raw_ext = RW'(raw_i);
  assign max_ext = RW'({LB{1'b1}});
  assign target  = (raw_ext > max_ext) ? {LB{1'b1}} : raw_ext[LB-1:0];

  // never-written slot reads as all zero
  assign cur   = state_vld_i ? lvl_i  : '0;
  assign pk    = state_vld_i ? peak_i : '0;
  assign hd    = state_vld_i ? hold_i : '0;

  assign coeff = (target > cur) ? attack_i : release_i;
  assign diff  = $signed({1'b0, target}) - $signed({1'b0, cur});
  assign prod  = $signed({1'b0, coeff}) * diff;
  assign dprod = pk * decay_i;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      cur_q   <= cur;
      peak_q  <= pk;
      hold_q  <= hd;
      prod_q  <= prod;
      dprod_q <= dprod;
    end
  end

  // arithmetic shift = floor divide by 2^16; magnitude stays below 2^LB
  assign step_full = prod_q >>> COEF_W;
  assign step      = $signed(step_full[LB+1:0]);
  assign sum       = $signed({2'b00, cur_q}) + step;

  always_comb begin
    priority if (sum[LB+1]) begin
      new_lvl = '0;
    end else if (sum[LB]) begin
      new_lvl = {LB{1'b1}};
    end else begin
      new_lvl = sum[LB-1:0];
    end
  end

  always_comb begin
    lvl_o = new_lvl;
    priority if (new_lvl >= peak_q) begin
      peak_o = new_lvl;
      hold_o = hold_ticks_i;
    end else if (hold_q != '0) begin
      peak_o = peak_q;
      hold_o = hold_q - HOLD_W'(1);
    end else begin
      // decayed peak is below the old peak, no saturation needed
      peak_o = dprod_q[DPROD_W-1:COEF_W];
      hold_o = hold_q;
    end
  end

endmodule

// ----- sv/slmb_merge.sv -----
// Merge stage: joins both lanes into one result beat and holds it in the output register.
`timescale 1ns / 1ps

module slmb_merge #(
  parameter int LEVEL_BITS = slmb_pkg::LEVEL_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  slmb_pkg::stage_ctl_t               ctl_i,
  input  logic [LEVEL_BITS-1:0]              lvl_l_i,
  input  logic [LEVEL_BITS-1:0]              lvl_r_i,
  input  logic [LEVEL_BITS-1:0]              peak_l_i,
  input  logic [LEVEL_BITS-1:0]              peak_r_i,
  output logic                               load_o,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [slmb_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  output logic [slmb_pkg::OUT_TUSER_W-1:0]   m_axis_tuser
);
  import slmb_pkg::*;

  logic                   vld_q;
  logic [OUT_TDATA_W-1:0] data_q;
  logic [OUT_TDATA_W-1:0] data_d;
  logic [OUT_TUSER_W-1:0] user_q;
  logic [OUT_TUSER_W-1:0] user_d;
  logic                   present;

  assign load_o  = !vld_q || m_axis_tready;
  assign present = ctl_i.in_range && ((lvl_l_i != '0) || (lvl_r_i != '0));

  always_comb begin
    if (ctl_i.in_range) begin
      data_d = {OUT_W'(peak_r_i), OUT_W'(peak_l_i), OUT_W'(lvl_r_i), OUT_W'(lvl_l_i)};
    end else begin
      data_d = '0;
    end
    user_d = {present, ctl_i.slot};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (load_o) begin
      vld_q <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_o && ctl_i.valid) begin
      data_q <= data_d;
      user_q <= user_d;
    end
  end

  assign m_axis_tvalid = vld_q;
  assign m_axis_tdata  = data_q;
  assign m_axis_tuser  = user_q;

endmodule

// ----- tb/sv/stereo_level_meter_ballistics_tb.sv -----
// Self-checking testbench for the stereo level meter ballistics block.
`timescale 1ns / 1ps

module stereo_level_meter_ballistics_tb;
  import slmb_pkg::*;

  localparam int NSLOTS = SLOTS_DEF;

  typedef struct {
    logic [SLOT_IDX_W-1:0] slot;
    logic [OUT_W-1:0]      smooth_l;
    logic [OUT_W-1:0]      smooth_r;
    logic [OUT_W-1:0]      peak_l;
    logic [OUT_W-1:0]      peak_r;
    logic                  present;
  } meter_result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                   tick_valid = 1'b0;
  logic                   tick_ready;
  logic [IN_TDATA_W-1:0]  tick_data  = '0;
  logic [IN_TUSER_W-1:0]  tick_user  = '0;
  logic                   res_valid;
  logic                   res_ready  = 1'b0;
  logic [OUT_TDATA_W-1:0] res_data;
  logic [OUT_TUSER_W-1:0] res_user;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [CFG_ADDR_W-1:0]  cfg_addr   = '0;
  logic [CFG_DATA_W-1:0]  cfg_data   = '0;

  always #2 clk_i = ~clk_i;

  stereo_level_meter_ballistics u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (tick_valid),
    .s_axis_tready (tick_ready),
    .s_axis_tdata  (tick_data),
    .s_axis_tuser  (tick_user),
    .m_axis_tvalid (res_valid),
    .m_axis_tready (res_ready),
    .m_axis_tdata  (res_data),
    .m_axis_tuser  (res_user),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_addr_i    (cfg_addr),
    .cfg_data_i    (cfg_data)
  );

  // Meter state mirror and register copies
  logic [OUT_W-1:0]  lvl_l  [NSLOTS];
  logic [OUT_W-1:0]  lvl_r  [NSLOTS];
  logic [OUT_W-1:0]  pk_l   [NSLOTS];
  logic [OUT_W-1:0]  pk_r   [NSLOTS];
  logic [HOLD_W-1:0] hold_l [NSLOTS];
  logic [HOLD_W-1:0] hold_r [NSLOTS];
  logic [COEF_W-1:0] gain_up    = ATTACK_RST;
  logic [COEF_W-1:0] gain_down  = RELEASE_RST;
  logic [COEF_W-1:0] decay_mult = DECAY_RST;
  logic [HOLD_W-1:0] hold_len   = HOLD_RST;

  meter_result_t meter_q[$];
  int  mismatch_cnt = 0;
  bit  tx_gaps_en   = 1'b1;
  bit  rx_gaps_en   = 1'b1;
  int  rx_hold_req  = 0;
  int  rx_stall_left = 0;

  initial begin
    for (int i = 0; i < NSLOTS; i++) begin
      lvl_l[i] = '0; lvl_r[i] = '0; pk_l[i] = '0; pk_r[i] = '0;
      hold_l[i] = '0; hold_r[i] = '0;
    end
  end

  function automatic longint clamp_level(input longint v);
    if (v < 0) return 0;
    if (v > longint'((1 << OUT_W) - 1)) return longint'((1 << OUT_W) - 1);
    return v;
  endfunction

  // One-pole follower; >>> on a signed longint floors toward minus infinity
  function automatic logic [OUT_W-1:0] follow_level(input logic [OUT_W-1:0] cur,
                                                    input logic [RAW_W-1:0] raw);
    longint gain;
    longint diff;
    longint nxt;
    gain = (raw > cur) ? longint'(gain_up) : longint'(gain_down);
    diff = longint'(raw) - longint'(cur);
    nxt  = longint'(cur) + ((gain * diff) >>> 16);
    return OUT_W'(clamp_level(nxt));
  endfunction

  function automatic void track_peak(input logic [OUT_W-1:0] level,
                                     inout logic [OUT_W-1:0] peak,
                                     inout logic [HOLD_W-1:0] hold);
    if (level >= peak) begin
      peak = level;
      hold = hold_len;
    end else if (hold > 0) begin
      hold = hold - 1'b1;
    end else begin
      peak = OUT_W'(clamp_level((longint'(peak) * longint'(decay_mult)) >>> 16));
    end
  endfunction

  function automatic meter_result_t predict_tick(input int s, input logic [RAW_W-1:0] l,
                                                 input logic [RAW_W-1:0] r);
    meter_result_t res;
    logic [OUT_W-1:0]  p;
    logic [HOLD_W-1:0] h;
    lvl_l[s] = follow_level(lvl_l[s], l);
    lvl_r[s] = follow_level(lvl_r[s], r);
    p = pk_l[s]; h = hold_l[s];
    track_peak(lvl_l[s], p, h);
    pk_l[s] = p; hold_l[s] = h;
    p = pk_r[s]; h = hold_r[s];
    track_peak(lvl_r[s], p, h);
    pk_r[s] = p; hold_r[s] = h;
    res.slot     = SLOT_IDX_W'(s);
    res.smooth_l = lvl_l[s];
    res.smooth_r = lvl_r[s];
    res.peak_l   = pk_l[s];
    res.peak_r   = pk_r[s];
    res.present  = (lvl_l[s] != 0) || (lvl_r[s] != 0);
    return res;
  endfunction

  function automatic logic [RAW_W-1:0] pick_level();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return RAW_W'($urandom_range(0, 255));
      3:       return RAW_W'($urandom_range(65280, 65535));
      default: return RAW_W'($urandom());
    endcase
  endfunction

  function automatic logic [COEF_W-1:0] pick_coeff();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return COEF_W'($urandom());
    endcase
  endfunction

  // Sender: drives at the falling edge, beat accepted at the rising edge
  task automatic send_tick(input int s, input logic [RAW_W-1:0] l, input logic [RAW_W-1:0] r);
    int gap;
    gap = (tx_gaps_en && $urandom_range(0, 4) == 0) ? $urandom_range(1, 7) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      tick_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    tick_valid <= 1'b1;
    tick_data  <= {r, l};
    tick_user  <= SLOT_IDX_W'(s);
    @(posedge clk_i);
    while (!tick_ready) @(posedge clk_i);
    meter_q.push_back(predict_tick(s, l, r));
  endtask

  // Stop offering and let every expected beat come out, plus the pipe latency
  task automatic wait_for_drain();
    @(negedge clk_i);
    tick_valid <= 1'b0;
    while (meter_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= val;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    case (idx)
      CFG_ATTACK:  gain_up    = val;
      CFG_RELEASE: gain_down  = val;
      CFG_DECAY:   decay_mult = val;
      CFG_HOLD:    hold_len   = val[HOLD_W-1:0];
      default:     ;
    endcase
  endtask

  task automatic write_meter_config(input logic [COEF_W-1:0] atk, input logic [COEF_W-1:0] rel,
                                    input logic [COEF_W-1:0] dec, input logic [HOLD_W-1:0] hld);
    wait_for_drain();
    write_reg(CFG_ATTACK, atk);
    write_reg(CFG_RELEASE, rel);
    write_reg(CFG_DECAY, dec);
    write_reg(CFG_HOLD, CFG_DATA_W'(hld));
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // A burst: loud hit then quiet tail on one slot (hold and decay), or random ticks
  task automatic send_burst(input int len);
    int s;
    int kind;
    s    = $urandom_range(0, NSLOTS - 1);
    kind = $urandom_range(0, 9);
    for (int i = 0; i < len; i++) begin
      if (kind < 4) begin
        send_tick($urandom_range(0, NSLOTS - 1), pick_level(), pick_level());
      end else if (kind < 8) begin
        if (i == 0)
          send_tick(s, RAW_W'($urandom_range(32768, 65535)), RAW_W'($urandom_range(32768, 65535)));
        else if ($urandom_range(0, 5) == 0)
          send_tick($urandom_range(0, NSLOTS - 1), pick_level(), pick_level());
        else
          send_tick(s, RAW_W'($urandom_range(0, 64)), RAW_W'($urandom_range(0, 64)));
      end else begin
        send_tick(s, RAW_W'($urandom()), RAW_W'($urandom()));
      end
    end
  endtask

  task automatic send_random(input int n);
    int sent;
    int len;
    sent = 0;
    while (sent < n) begin
      len = $urandom_range(1, 12);
      if (len > n - sent) len = n - sent;
      send_burst(len);
      sent += len;
    end
  endtask

  // Reset register values, field extremes on the edge slots
  task automatic test_reset_defaults();
    send_tick(0, '0, '0);
    send_tick(0, '1, '0);
    send_tick(7, '0, '1);
    send_tick(7, '1, '1);
    send_tick(0, '1, '1);
    send_tick(3, 16'h5555, 16'hAAAA);
    send_tick(3, '0, '0);
    send_tick(7, '0, '0);
  endtask

  // Zero gains freeze the level; full gains jump almost to the target
  task automatic test_coeff_extremes();
    write_meter_config('0, '0, '0, '0);
    send_tick(0, '1, '1);
    send_tick(7, '0, '0);
    send_tick(5, '1, '0);
    write_meter_config('1, '1, '1, 8'hFF);
    send_tick(5, '1, '1);
    send_tick(5, '0, '1);
    send_tick(5, '1, '0);
  endtask

  // Peak held for a few ticks, then multiplied down each tick
  task automatic test_hold_decay();
    write_meter_config('1, '1, 16'h8000, 8'd3);
    send_tick(2, '1, 16'h8000);
    for (int i = 0; i < 6; i++) send_tick(2, '0, '0);
  endtask

  // Several register settings, extremes first
  task automatic test_random_phases();
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0:       write_meter_config('0, '0, '0, '0);
        1:       write_meter_config('1, '1, '1, 8'hFF);
        2:       write_meter_config(ATTACK_RST, RELEASE_RST, DECAY_RST, HOLD_RST);
        default: write_meter_config(pick_coeff(), pick_coeff(), pick_coeff(),
                                    ($urandom_range(0, 4) == 0) ? HOLD_W'($urandom())
                                                                : HOLD_W'($urandom_range(0, 6)));
      endcase
      send_random(50);
    end
  endtask

  // Receiver holds off long while the sender keeps offering back to back
  task automatic test_backpressure();
    write_meter_config(pick_coeff(), pick_coeff(), pick_coeff(), HOLD_W'($urandom_range(0, 4)));
    tx_gaps_en  = 1'b0;
    rx_hold_req = 120;
    send_random(40);
    tx_gaps_en  = 1'b1;
  endtask

  // Sender pauses until every expected beat has come
  task automatic test_drain_pause();
    send_random(10);
    wait_for_drain();
    send_random(10);
  endtask

  // Last part: no idling on either side
  task automatic test_full_rate();
    write_meter_config(pick_coeff(), pick_coeff(), pick_coeff(), HOLD_W'($urandom_range(0, 8)));
    tx_gaps_en = 1'b0;
    rx_gaps_en = 1'b0;
    send_random(120);
  endtask

  // Receiver ready: random low bursts, plus requested long hold-off
  always @(negedge clk_i) begin
    if (rx_hold_req > 0) begin
      rx_stall_left = rx_hold_req;
      rx_hold_req   = 0;
    end else if (rx_stall_left == 0 && rx_gaps_en && rst_ni && $urandom_range(0, 5) == 0) begin
      rx_stall_left = $urandom_range(1, 7);
    end
    if (rx_stall_left > 0) begin
      res_ready <= 1'b0;
      rx_stall_left--;
    end else begin
      res_ready <= rst_ni;
    end
  end

  // Result check: each beat against the oldest expectation
  always @(posedge clk_i) begin
    meter_result_t want;
    meter_result_t got;
    if (rst_ni && res_valid && res_ready) begin
      got.slot     = res_user[SLOT_IDX_W-1:0];
      got.present  = res_user[SLOT_IDX_W];
      got.smooth_l = res_data[0*OUT_W +: OUT_W];
      got.smooth_r = res_data[1*OUT_W +: OUT_W];
      got.peak_l   = res_data[2*OUT_W +: OUT_W];
      got.peak_r   = res_data[3*OUT_W +: OUT_W];
      if (meter_q.size() == 0) begin
        $error("unexpected result beat, out_slot %0d", got.slot);
        mismatch_cnt++;
      end else begin
        want = meter_q.pop_front();
        if (got.slot !== want.slot) begin
          $error("out_slot expected %0d actual %0d", want.slot, got.slot);
          mismatch_cnt++;
        end
        if (got.smooth_l !== want.smooth_l) begin
          $error("smooth_left expected %0d actual %0d", want.smooth_l, got.smooth_l);
          mismatch_cnt++;
        end
        if (got.smooth_r !== want.smooth_r) begin
          $error("smooth_right expected %0d actual %0d", want.smooth_r, got.smooth_r);
          mismatch_cnt++;
        end
        if (got.peak_l !== want.peak_l) begin
          $error("peak_left expected %0d actual %0d", want.peak_l, got.peak_l);
          mismatch_cnt++;
        end
        if (got.peak_r !== want.peak_r) begin
          $error("peak_right expected %0d actual %0d", want.peak_r, got.peak_r);
          mismatch_cnt++;
        end
        if (got.present !== want.present) begin
          $error("signal_present expected %0d actual %0d", want.present, got.present);
          mismatch_cnt++;
        end
      end
    end
  end

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);
    test_reset_defaults();
    test_coeff_extremes();
    test_hold_decay();
    test_random_phases();
    test_backpressure();
    test_drain_pause();
    test_full_rate();
    wait_for_drain();
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Run limit, far above the slowest correct run
  initial begin
    #4_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ----- files.f -----
sv/slmb_pkg.sv
sv/slmb_lane.sv
sv/slmb_merge.sv
sv/stereo_level_meter_ballistics.sv
tb/sv/stereo_level_meter_ballistics_tb.sv
